// ===== rtl/core/bmhq_pkg.sv =====
package bmhq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 6;
  localparam int unsigned CapW = 6;
  localparam int unsigned StatusW = 2;

  localparam logic [CapW-1:0] CapReset = 6'd32;

  localparam logic KindPush = 1'b0;
  localparam logic KindPop  = 1'b1;

  localparam logic [StatusW-1:0] StatusDone      = 2'd0;
  localparam logic [StatusW-1:0] StatusPushFull  = 2'd1;
  localparam logic [StatusW-1:0] StatusPopEmpty  = 2'd2;

  typedef struct packed {
    logic                     kind;
    logic signed [ValueW-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [ValueW-1:0] top_value;
    logic                     top_valid;
    logic [CountW-1:0]        count;
    logic [StatusW-1:0]       status;
  } out_word_t;

  // Which heap slot the RAM read port looks at.
  typedef enum logic [2:0] {
    RdParent,
    RdLast,
    RdLeft,
    RdRight,
    RdRoot
  } rd_sel_e;

  // What is written into the slot under the walking node.
  typedef enum logic [1:0] {
    WrCur,
    WrRdata,
    WrLeft
  } wr_sel_e;

  // Next value of the walking node.
  typedef enum logic [2:0] {
    NodeHold,
    NodeNew,
    NodeParent,
    NodeRoot,
    NodeLeft,
    NodeRight
  } node_sel_e;

  typedef struct packed {
    logic                rd_en;
    rd_sel_e             rd_sel;
    logic                wr_en;
    wr_sel_e             wr_sel;
    node_sel_e           node_sel;
    logic                cur_from_value;
    logic                cur_from_rdata;
    logic                count_inc;
    logic                count_dec;
    logic                left_load;
    logic                status_load;
    logic [StatusW-1:0]  status_code;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic node_root;
    logic has_left;
    logic has_right;
    logic up_greater;
    logic left_wins;
    logic right_wins;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/bmhq_ram.sv =====
module bmhq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bmhq_dp.sv =====
module bmhq_dp #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bmhq_pkg::in_word_t          in_word_i,
  input  logic                        cfg_valid_i,
  input  logic [bmhq_pkg::CapW-1:0]   cfg_data_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output bmhq_pkg::out_word_t         out_word_o,
  input  bmhq_pkg::cmd_t              cmd_i,
  output bmhq_pkg::stat_t             stat_o
);

  import bmhq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > CountW) ? CW : CountW;

  logic [CW-1:0]          count_q, count_d;
  logic [CapW-1:0]        capacity_q;
  logic [CW-1:0]          node_q, node_d;
  logic signed [ValueW-1:0] cur_q, left_q;
  logic [StatusW-1:0]     status_q;
  out_word_t              out_q;
  logic                   out_valid_q;

  logic [ValueW-1:0]      rdata;
  logic [CW:0]            left_w, right_w;
  logic [CW-1:0]          rd_slot, rd_slot_m1, wr_slot_m1;
  logic [ValueW-1:0]      wdata;
  logic [CMPW-1:0]        count_ext, cap_ext, depth_ext, eff_cap;
  logic signed [ValueW-1:0] best_so_far;

  assign left_w  = {node_q, 1'b0};
  assign right_w = left_w + 1'b1;

  always_comb begin
    case (cmd_i.rd_sel)
      RdParent: rd_slot = node_q >> 1;
      RdLast:   rd_slot = count_q;
      RdLeft:   rd_slot = left_w[CW-1:0];
      RdRight:  rd_slot = right_w[CW-1:0];
      default:  rd_slot = CW'(1);
    endcase
  end

  assign rd_slot_m1 = rd_slot - 1'b1;
  assign wr_slot_m1 = node_q - 1'b1;

  always_comb begin
    case (cmd_i.wr_sel)
      WrRdata: wdata = rdata;
      WrLeft:  wdata = left_q;
      default: wdata = cur_q;
    endcase
  end

  bmhq_ram #(
    .WIDTH (ValueW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (wr_slot_m1[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_slot_m1[AW-1:0]),
    .rdata_o (rdata)
  );

  // A capacity above the heap depth acts as the depth.
  assign count_ext = CMPW'(count_q);
  assign cap_ext   = CMPW'(capacity_q);
  assign depth_ext = CMPW'(DEPTH);
  assign eff_cap   = (cap_ext > depth_ext) ? depth_ext : cap_ext;

  assign best_so_far = stat_o.left_wins ? left_q : cur_q;

  assign stat_o.full       = count_ext >= eff_cap;
  assign stat_o.empty      = count_q == '0;
  assign stat_o.node_root  = node_q == CW'(1);
  assign stat_o.has_left   = left_w <= {1'b0, count_q};
  assign stat_o.has_right  = right_w <= {1'b0, count_q};
  assign stat_o.up_greater = cur_q > $signed(rdata);
  assign stat_o.left_wins  = left_q > cur_q;
  assign stat_o.right_wins = $signed(rdata) > best_so_far;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    count_d = count_q;
    if (cmd_i.count_inc) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.count_dec) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    case (cmd_i.node_sel)
      NodeNew:    node_d = count_q + 1'b1;
      NodeParent: node_d = node_q >> 1;
      NodeRoot:   node_d = CW'(1);
      NodeLeft:   node_d = left_w[CW-1:0];
      NodeRight:  node_d = right_w[CW-1:0];
      default:    node_d = node_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      capacity_q  <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_valid_i) begin
        capacity_q <= cfg_data_i;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    if (cmd_i.cur_from_value) begin
      cur_q <= in_word_i.value;
    end else if (cmd_i.cur_from_rdata) begin
      cur_q <= rdata;
    end
    if (cmd_i.left_load) begin
      left_q <= rdata;
    end
    if (cmd_i.status_load) begin
      status_q <= cmd_i.status_code;
    end
    // The root has just been read back; an empty heap shows zero.
    if (cmd_i.out_load) begin
      out_q.top_valid <= !stat_o.empty;
      out_q.top_value <= stat_o.empty ? '0 : rdata;
      out_q.count     <= count_ext[CountW-1:0];
      out_q.status    <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== rtl/core/bmhq_ctrl.sv =====
module bmhq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_kind_i,
  output logic            in_stall_o,
  input  bmhq_pkg::stat_t stat_i,
  output bmhq_pkg::cmd_t  cmd_o
);

  import bmhq_pkg::*;

  typedef enum logic [8:0] {
    SIdle    = 9'b000000001,
    SUpRd    = 9'b000000010,
    SUpCmp   = 9'b000000100,
    SDnLast  = 9'b000001000,
    SDnRdL   = 9'b000010000,
    SDnRdR   = 9'b000100000,
    SDnCmp   = 9'b001000000,
    STopRd   = 9'b010000000,
    SDone    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.rd_sel   = RdRoot;
    cmd_o.wr_sel   = WrCur;
    cmd_o.node_sel = NodeHold;
    cmd_o.status_code = StatusDone;

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.status_load = 1'b1;
          if (in_kind_i == KindPush) begin
            if (stat_i.full) begin
              cmd_o.status_code = StatusPushFull;
              state_d = STopRd;
            end else begin
              cmd_o.count_inc      = 1'b1;
              cmd_o.cur_from_value = 1'b1;
              cmd_o.node_sel       = NodeNew;
              state_d = SUpRd;
            end
          end else begin
            if (stat_i.empty) begin
              cmd_o.status_code = StatusPopEmpty;
              state_d = STopRd;
            end else begin
              // Fetch the last entry while the count drops by one.
              cmd_o.rd_en     = 1'b1;
              cmd_o.rd_sel    = RdLast;
              cmd_o.count_dec = 1'b1;
              state_d = SDnLast;
            end
          end
        end
      end
      SUpRd: begin
        if (stat_i.node_root) begin
          cmd_o.wr_en = 1'b1;
          state_d = STopRd;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RdParent;
          state_d = SUpCmp;
        end
      end
      SUpCmp: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.up_greater) begin
          // The parent moves down into the hole and the walk climbs.
          cmd_o.wr_sel   = WrRdata;
          cmd_o.node_sel = NodeParent;
          state_d = SUpRd;
        end else begin
          state_d = STopRd;
        end
      end
      SDnLast: begin
        cmd_o.cur_from_rdata = 1'b1;
        cmd_o.node_sel       = NodeRoot;
        state_d = SDnRdL;
      end
      SDnRdL: begin
        if (stat_i.has_left) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RdLeft;
          state_d = SDnRdR;
        end else begin
          cmd_o.wr_en = 1'b1;
          state_d = STopRd;
        end
      end
      SDnRdR: begin
        cmd_o.left_load = 1'b1;
        if (stat_i.has_right) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RdRight;
        end
        state_d = SDnCmp;
      end
      SDnCmp: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.has_right && stat_i.right_wins) begin
          cmd_o.wr_sel   = WrRdata;
          cmd_o.node_sel = NodeRight;
          state_d = SDnRdL;
        end else if (stat_i.left_wins) begin
          cmd_o.wr_sel   = WrLeft;
          cmd_o.node_sel = NodeLeft;
          state_d = SDnRdL;
        end else begin
          state_d = STopRd;
        end
      end
      STopRd: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RdRoot;
        state_d = SDone;
      end
      SDone: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != SIdle;

endmodule

// ===== rtl/core/binary_max_heap_queue.sv =====
// Channel   Direction  Handshake                 Word
// in        input      in_valid_i / in_stall_o   in_word_t: kind, value
// out       output     out_valid_o / out_stall_i out_word_t: top_value, top_valid, count, status
// cfg       input      cfg_valid_i / cfg_ready_o capacity (6 bits)
//
// One word is handled at a time; a refused push or pop skips the walk. A push
// walks up and a pop walks down the heap level by level; each level costs one
// read of the heap RAM (a pop reads both children), which has one read port and
// one write port and registered read data, and one compare and write. The root
// is read back once more at the end of every word. Reset clears the count and the
// result valid flag and sets capacity to 32; the heap RAM itself is not cleared. A
// stalled result holds in its register while the next word is already worked on.
module binary_max_heap_queue #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bmhq_pkg::in_word_t         in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bmhq_pkg::out_word_t        out_word_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bmhq_pkg::CapW-1:0]  cfg_data_i
);

  import bmhq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  bmhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_word_i.kind),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bmhq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ===== rtl/core/bmhq_sva.sv =====
module bmhq_sva (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input bmhq_pkg::out_word_t  out_word_o
);

  import bmhq_pkg::*;

  // The valid flag follows the count.
  a_valid_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.top_valid == (out_word_o.count != '0)))
    else $error("top_valid disagrees with count");

  // An empty heap shows a zero top.
  a_empty_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.top_valid) |-> (out_word_o.top_value == '0))
    else $error("empty heap shows a nonzero top");

  // A pop is only refused on an empty heap.
  a_pop_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status == StatusPopEmpty) |-> (out_word_o.count == '0))
    else $error("pop refused while entries remain");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled result changed");

endmodule

bind binary_max_heap_queue bmhq_sva u_bmhq_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

// ===== dv/binary_max_heap_queue_test.sv =====
module binary_max_heap_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bmhq_pkg::*;

  localparam int unsigned HeapDepth = 32;
  localparam int unsigned ItemTarget = 1850;
  localparam int unsigned PhaseItems = 120;
  localparam int unsigned MaxWait = 18;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned CycleLimit = 1000000;
  localparam logic signed [ValueW-1:0] ValMax = 32'sh7fffffff;
  localparam logic signed [ValueW-1:0] ValMin = 32'sh80000000;

  typedef struct {
    bit              is_cfg;
    logic [CapW-1:0] cap;
    in_word_t        word;
    bit              fixed;
    out_word_t       want;
  } step_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  in_word_t        in_word_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_word_t       out_word_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [CapW-1:0] cfg_data_i = '0;

  // A typed expectation travels beside the word it belongs to.
  logic      want_fixed = 1'b0;
  out_word_t want_word = '0;

  // Shadow copy of the heap and its settings.
  logic signed [ValueW-1:0] heap_q [1:HeapDepth];
  int unsigned              fill_q = 0;
  logic [CapW-1:0]          cap_q = CapReset;
  out_word_t                heap_results_q [$];

  int unsigned errors = 0;
  int unsigned done_pushes = 0;
  int unsigned done_pops = 0;
  int unsigned full_hits = 0;
  int unsigned empty_hits = 0;
  int unsigned cap_writes = 0;
  int unsigned cycles = 0;
  int unsigned rx_wait = 0;
  logic        rx_calm = 1'b0;
  bit          tx_calm = 1'b0;

  binary_max_heap_queue #(
    .DEPTH(HeapDepth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic out_word_t heap_apply(input in_word_t w);
    out_word_t                r;
    int unsigned              limit;
    int unsigned              node;
    int unsigned              best;
    logic signed [ValueW-1:0] tmp;
    limit = (cap_q > HeapDepth) ? HeapDepth : cap_q;
    r = '0;
    r.status = StatusDone;
    if (w.kind == KindPush) begin
      if (fill_q >= limit) begin
        r.status = StatusPushFull;
      end else begin
        fill_q++;
        heap_q[fill_q] = w.value;
        node = fill_q;
        while (node > 1 && heap_q[node] > heap_q[node / 2]) begin
          tmp = heap_q[node];
          heap_q[node] = heap_q[node / 2];
          heap_q[node / 2] = tmp;
          node = node / 2;
        end
      end
    end else if (fill_q == 0) begin
      r.status = StatusPopEmpty;
    end else begin
      // The last entry takes the root's place and walks down toward the
      // larger child; ties keep the left child.
      heap_q[1] = heap_q[fill_q];
      fill_q--;
      node = 1;
      while (2 * node <= fill_q) begin
        best = node;
        if (heap_q[2 * node] > heap_q[best]) best = 2 * node;
        if (2 * node + 1 <= fill_q && heap_q[2 * node + 1] > heap_q[best]) best = 2 * node + 1;
        if (best == node) break;
        tmp = heap_q[node];
        heap_q[node] = heap_q[best];
        heap_q[best] = tmp;
        node = best;
      end
    end
    r.top_valid = (fill_q != 0);
    r.top_value = (fill_q != 0) ? heap_q[1] : '0;
    r.count = fill_q[CountW-1:0];
    return r;
  endfunction

  function automatic out_word_t result(input logic signed [ValueW-1:0] top,
                                       input logic vld, input logic [CountW-1:0] cnt,
                                       input logic [StatusW-1:0] st);
    out_word_t r;
    r.top_value = top;
    r.top_valid = vld;
    r.count = cnt;
    r.status = st;
    return r;
  endfunction

  function automatic step_row_t act(input logic kind, input logic signed [ValueW-1:0] value,
                                    input bit fixed, input out_word_t want);
    step_row_t r;
    r.is_cfg = 1'b0;
    r.cap = '0;
    r.word.kind = kind;
    r.word.value = value;
    r.fixed = fixed;
    r.want = want;
    return r;
  endfunction

  function automatic step_row_t reconf(input logic [CapW-1:0] cap);
    step_row_t r;
    r.is_cfg = 1'b1;
    r.cap = cap;
    r.word = '0;
    r.fixed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic send_word(input in_word_t w, input bit fixed, input out_word_t want);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_word_i <= w;
    want_fixed <= fixed;
    want_word <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    gap = tx_calm ? 0 : $urandom_range(0, MaxWait);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every word has come back and the block is quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (heap_results_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CapW-1:0] cap);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : monitor
    out_word_t predicted;
    out_word_t expected;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q = cfg_data_i;
        cap_writes++;
      end
      if (in_valid_i && !in_stall_o) begin
        predicted = heap_apply(in_word_i);
        if (predicted.status == StatusPushFull) full_hits++;
        else if (predicted.status == StatusPopEmpty) empty_hits++;
        else if (in_word_i.kind == KindPush) done_pushes++;
        else done_pops++;
        heap_results_q.push_back(want_fixed ? want_word : predicted);
      end
      if (out_valid_o && !out_stall_i) begin
        if (heap_results_q.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected, got %p", $time, out_word_o);
        end else begin
          expected = heap_results_q.pop_front();
          check_field("top_value", longint'(expected.top_value),
                      longint'(out_word_o.top_value));
          check_field("top_valid", longint'(expected.top_valid),
                      longint'(out_word_o.top_valid));
          check_field("count", longint'(expected.count), longint'(out_word_o.count));
          check_field("status", longint'(expected.status), longint'(out_word_o.status));
        end
      end
    end
  end

  // The receiver holds off for a fresh random wait after each word.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) rx_wait = rx_calm ? 0 : $urandom_range(0, MaxWait);
    else if (rx_wait != 0) rx_wait--;
    out_stall_i <= (rx_wait != 0);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("%0t: run did not finish in %0d cycles", $time, CycleLimit);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    step_row_t                plan [$];
    int unsigned              phase;
    int unsigned              slot;
    int unsigned              push_pct;
    int unsigned              pause_at;
    logic [CapW-1:0]          cap;
    logic signed [ValueW-1:0] v;
    in_word_t                 w;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan.push_back(act(KindPop, '0, 1'b1, result('0, 1'b0, 6'd0, StatusPopEmpty)));
    plan.push_back(act(KindPush, ValMax, 1'b1, result(ValMax, 1'b1, 6'd1, StatusDone)));
    plan.push_back(act(KindPush, ValMin, 1'b1, result(ValMax, 1'b1, 6'd2, StatusDone)));
    plan.push_back(act(KindPush, 0, 1'b0, '0));
    plan.push_back(act(KindPush, -1, 1'b0, '0));
    plan.push_back(act(KindPush, ValMax, 1'b0, '0));
    plan.push_back(act(KindPush, 5, 1'b0, '0));
    repeat (5) plan.push_back(act(KindPop, '0, 1'b0, '0));
    plan.push_back(act(KindPop, '0, 1'b1, result('0, 1'b0, 6'd0, StatusDone)));
    plan.push_back(act(KindPop, '0, 1'b1, result('0, 1'b0, 6'd0, StatusPopEmpty)));
    plan.push_back(reconf(6'd1));
    plan.push_back(act(KindPush, -7, 1'b1, result(-7, 1'b1, 6'd1, StatusDone)));
    plan.push_back(act(KindPush, 9, 1'b1, result(-7, 1'b1, 6'd1, StatusPushFull)));
    plan.push_back(reconf(6'd0));
    plan.push_back(act(KindPush, 3, 1'b1, result(-7, 1'b1, 6'd1, StatusPushFull)));
    plan.push_back(act(KindPop, '0, 1'b1, result('0, 1'b0, 6'd0, StatusDone)));
    plan.push_back(reconf('1));
    plan.push_back(act(KindPush, 100, 1'b0, '0));
    plan.push_back(act(KindPush, 200, 1'b0, '0));
    // Capacity drops below the count: the stored entries stay, pushes bounce.
    plan.push_back(reconf(6'd1));
    plan.push_back(act(KindPush, -3, 1'b1, result(200, 1'b1, 6'd2, StatusPushFull)));
    plan.push_back(act(KindPop, '0, 1'b0, '0));
    plan.push_back(act(KindPop, '0, 1'b1, result('0, 1'b0, 6'd0, StatusDone)));
    plan.push_back(act(KindPop, '0, 1'b1, result('0, 1'b0, 6'd0, StatusPopEmpty)));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_capacity(plan[i].cap);
      else send_word(plan[i].word, plan[i].fixed, plan[i].want);
    end

    // Random phases, each with its own capacity, push/pop mix and pacing.
    phase = 0;
    while (done_pushes + done_pops + full_hits + empty_hits < ItemTarget && phase < 80) begin
      case (phase)
        0: cap = CapReset;
        1: cap = '1;
        2: cap = 6'd1;
        3: cap = 6'd0;
        default: begin
          if ($urandom_range(0, 7) == 0) cap = CapW'($urandom_range(HeapDepth + 1, 63));
          else cap = CapW'($urandom_range(1, HeapDepth));
        end
      endcase
      set_capacity(cap);
      case ($urandom_range(0, 3))
        0: push_pct = 80;
        1: push_pct = 50;
        2: push_pct = 30;
        default: push_pct = 60;
      endcase
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm <= ($urandom_range(0, 3) == 0);
      pause_at = (phase % 3 == 1) ? $urandom_range(1, PhaseItems - 1) : PhaseItems;
      for (slot = 0; slot < PhaseItems; slot++) begin
        if (slot == pause_at) settle();
        // Narrow values make ties common, which exercises the child choice.
        case ($urandom_range(0, 3))
          0: v = $urandom_range(0, 15) - 8;
          1: begin
            case ($urandom_range(0, 3))
              0: v = ValMax;
              1: v = ValMin;
              2: v = 0;
              default: v = -1;
            endcase
          end
          default: v = $urandom;
        endcase
        w.kind = ($urandom_range(0, 99) < push_pct) ? KindPush : KindPop;
        w.value = v;
        send_word(w, 1'b0, '0);
      end
      phase++;
    end

    settle();
    $display("Heap changed by %0d pushes and %0d pops; %0d pushes hit a full heap, %0d pops an empty one.",
             done_pushes, done_pops, full_hits, empty_hits);
    $display("Capacity rewritten %0d times across %0d random phases, 0 and 63 included.",
             cap_writes, phase);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
